FILE: design/adc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_pkg
// Shared types, constants and tables of the dB compressor core.
// ---------------------------------------------------------------------------
package adc_pkg;

  localparam int SampleW = 16;
  localparam int CfgW    = 17;
  localparam int MantW   = 31;
  localparam int NumFrac = 16;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SLOPE     = 2'd1;
  localparam logic [1:0] CFG_ATTACK    = 2'd2;

  localparam logic signed [16:0] THRESHOLD_RST = -17'sd5120;
  localparam logic [15:0] SLOPE_RST  = 16'd43691;
  localparam logic [15:0] ATTACK_RST = 16'd44;

  localparam logic [19:0] LOG2_FS_POS = 20'd983037;
  localparam logic [19:0] LOG2_FS_NEG = 20'd983040;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0] LOG2_PER_DB = 22'd2786635;
  localparam logic [15:0] MIN_LEVEL_MAG = 16'd40960;

  typedef struct packed {
    logic       load;
    logic       log_step;
    logic       lvl_mul;
    logic       lvl_fin;
    logic       cmp;
    logic       mul1;
    logic       mul2;
    logic       div_init;
    logic       div_step;
    logic       exp_load;
    logic       mant_step;
    logic       mag_mul;
    logic       out_load;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic compress;
  } status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry k holds 2^30 * 2^(-2^-(k+1)), rounded down by the square root chain.
  function automatic logic [NumFrac*MantW-1:0] build_ctab();
    logic [NumFrac*MantW-1:0] tab;
    logic [63:0] c;
    tab = '0;
    c   = isqrt64(64'd1 << 59);
    for (int k = 0; k < NumFrac; k++) begin
      tab[k*MantW +: MantW] = c[MantW-1:0];
      c = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam logic [NumFrac*MantW-1:0] C_TAB = build_ctab();

endpackage

FILE: design/adc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_ctrl
// Sequencer of the compressor: steps the datapath through log, gain and
// exponent phases and owns the stream handshakes.
// ---------------------------------------------------------------------------
module adc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  adc_pkg::status_t status,
  output adc_pkg::cmd_t    cmd
);
  import adc_pkg::*;

  typedef enum logic [12:0] {
    IDLE     = 13'b0000000000001,
    LOG      = 13'b0000000000010,
    LVL_MUL  = 13'b0000000000100,
    LVL_FIN  = 13'b0000000001000,
    CMP      = 13'b0000000010000,
    MUL1     = 13'b0000000100000,
    MUL2     = 13'b0000001000000,
    DIV_INIT = 13'b0000010000000,
    DIV      = 13'b0000100000000,
    EXP      = 13'b0001000000000,
    MANT     = 13'b0010000000000,
    MAG      = 13'b0100000000000,
    DONE     = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic       out_go;

  assign s_tready = (state == IDLE);
  assign out_go   = (state == DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.idx    = step[3:0];
    unique case (state)
      IDLE: begin
        step_next = 5'd0;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = LOG;
        end
      end
      LOG: begin
        cmd.log_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == 5'd15) begin
          state_next = LVL_MUL;
        end
      end
      LVL_MUL: begin
        cmd.lvl_mul = 1'b1;
        state_next  = LVL_FIN;
      end
      LVL_FIN: begin
        cmd.lvl_fin = 1'b1;
        state_next  = CMP;
      end
      CMP: begin
        cmd.cmp    = 1'b1;
        state_next = status.compress ? MUL1 : DONE;
      end
      MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = MUL2;
      end
      MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = DIV_INIT;
      end
      DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = 5'd0;
        state_next   = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == 5'd16) begin
          state_next = EXP;
        end
      end
      EXP: begin
        cmd.exp_load = 1'b1;
        step_next    = 5'd0;
        state_next   = MANT;
      end
      MANT: begin
        cmd.mant_step = 1'b1;
        step_next     = step + 5'd1;
        if (step == 5'd15) begin
          state_next = MAG;
        end
      end
      MAG: begin
        cmd.mag_mul = 1'b1;
        state_next  = DONE;
      end
      DONE: begin
        if (out_go) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step     <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/adc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_datapath
// Registers and arithmetic of the compressor: log2 by squaring, level in dB,
// gain reduction with restoring division, and exponent by mantissa products.
// ---------------------------------------------------------------------------
module adc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [adc_pkg::CfgW-1:0] cfg_data,
  input  logic [15:0]           s_tdata,
  output logic [15:0]           m_tdata,
  input  adc_pkg::cmd_t         cmd,
  output adc_pkg::status_t      status
);
  import adc_pkg::*;

  logic signed [16:0] thr;
  logic [15:0] slope, attack, count;

  logic signed [15:0] smp;
  logic        neg, zero_in, full_in;
  logic [3:0]  e_reg;
  logic [15:0] x, frac;
  logic [38:0] lprod;
  logic signed [16:0] lvl;
  logic [16:0] r;
  logic [15:0] c;
  logic [32:0] rc;
  logic [48:0] p;
  logic [15:0] rem;
  logic [16:0] nsh, quo;
  logic [15:0] f;
  logic [3:0]  ip;
  logic        mag_zero;
  logic [30:0] mant;
  logic [45:0] p45;
  logic        bypass;

  logic [15:0] m_abs;
  logic [3:0]  e_comb;
  logic [15:0] x0;
  logic [31:0] sq;
  logic [16:0] xs;
  logic [19:0] l2, full, d;
  logic [39:0] qsum;
  logic [15:0] q;
  logic [15:0] a_eff, cnt_new;
  logic [16:0] rem17;
  logic        ge;
  logic [15:0] nl;
  logic [17:0] y;
  logic [39:0] tprod;
  logic [30:0] ck;
  logic [61:0] mprod;
  logic [45:0] shifted;
  logic [14:0] mag;
  logic [15:0] res;

  assign status.compress = (lvl > thr);

  always_comb begin
    m_abs  = s_tdata[15] ? 16'(-s_tdata) : s_tdata;
    e_comb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (m_abs[i]) e_comb = 4'(i);
    end
    x0 = m_abs << (4'd15 - e_comb);
  end

  always_comb begin
    sq    = 32'(x) * 32'(x);
    xs    = sq[31:15];
    l2    = {e_reg, frac};
    full  = neg ? LOG2_FS_NEG : LOG2_FS_POS;
    d     = (l2 >= full) ? 20'd0 : full - l2;
    qsum  = 40'(lprod) + 40'h80_0000;
    q     = (qsum[39:24] > 16'(MIN_LEVEL_MAG)) ? MIN_LEVEL_MAG : qsum[39:24];
    a_eff = (attack == 16'd0) ? 16'd1 : attack;
    cnt_new = (count < a_eff) ? count + 16'd1 : count;
    rem17 = {rem, nsh[16]};
    ge    = (rem17 >= {1'b0, a_eff});
    nl    = 16'(-lvl);
    y     = 18'(nl) + 18'(quo);
    tprod = 40'(y) * 40'(LOG2_PER_DB) + 40'd32768;
    ck    = C_TAB[9'(cmd.idx) * 9'd31 +: 31];
    mprod = 62'(mant) * 62'(ck);
    shifted = p45 >> (6'd30 + 6'(ip));
    mag   = mag_zero ? 15'd0 : shifted[14:0];
    res   = bypass ? smp : (neg ? 16'(-{1'b0, mag}) : {1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THRESHOLD_RST;
      slope  <= SLOPE_RST;
      attack <= ATTACK_RST;
      count  <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr    <= cfg_data;
          CFG_SLOPE:     slope  <= cfg_data[15:0];
          CFG_ATTACK:    attack <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.cmp && status.compress) begin
        count <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp     <= s_tdata;
      neg     <= s_tdata[15];
      zero_in <= (s_tdata == 16'h0000);
      full_in <= (s_tdata == 16'h7FFF) || (s_tdata == 16'h8000);
      e_reg   <= e_comb;
      x       <= x0;
      frac    <= 16'd0;
    end
    if (cmd.log_step) begin
      x    <= xs[16] ? xs[16:1] : xs[15:0];
      frac <= {frac[14:0], xs[16]};
    end
    if (cmd.lvl_mul) begin
      lprod <= 39'(d) * 39'(DB_PER_LOG2);
    end
    if (cmd.lvl_fin) begin
      lvl <= zero_in ? -17'sd40960 : (full_in ? 17'sd0 : 17'(-{1'b0, q}));
    end
    if (cmd.cmp) begin
      bypass <= !status.compress;
      r      <= 17'(18'(lvl) - 18'(thr));
      c      <= (cnt_new < a_eff) ? cnt_new : a_eff;
    end
    if (cmd.mul1) begin
      rc <= 33'(r) * 33'(c);
    end
    if (cmd.mul2) begin
      p <= 49'(rc) * 49'(slope);
    end
    if (cmd.div_init) begin
      rem <= p[48:33];
      nsh <= p[32:16];
      quo <= 17'd0;
    end
    if (cmd.div_step) begin
      rem <= ge ? 16'(rem17 - {1'b0, a_eff}) : rem17[15:0];
      nsh <= {nsh[15:0], 1'b0};
      quo <= {quo[15:0], ge};
    end
    if (cmd.exp_load) begin
      f        <= tprod[31:16];
      ip       <= tprod[35:32];
      mag_zero <= |tprod[39:36];
      mant     <= 31'h4000_0000;
    end
    if (cmd.mant_step) begin
      if (f[15]) begin
        mant <= mprod[60:30];
      end
      f <= {f[14:0], 1'b0};
    end
    if (cmd.mag_mul) begin
      p45 <= 46'd32767 * 46'(mant);
    end
    if (cmd.out_load) begin
      m_tdata <= res;
    end
  end

endmodule

FILE: design/audio_db_compressor_with_attack_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_db_compressor_with_attack_core
// Audio compressor on signed 16-bit PCM samples with an attack ramp.
// ---------------------------------------------------------------------------
// Samples arrive as requests on the s_ channel and leave on the m_ channel,
// one result request for each sample. The level of each sample is taken in
// dBFS; above the threshold the excess is reduced by the slope and by the
// attack ramp fraction, and the sample is rebuilt from the reduced level.
// A sample is worked on alone: s_tready is high only while the sequencer is
// idle. A sample at or below the threshold passes the 16-step log2 loop,
// the level steps and the compare on its way to m_tvalid; a compressed one
// also passes the gain products, the 17-step restoring divider and the
// 16-step mantissa product loop, and no new sample is taken meanwhile.
// The result sits in an output register, so the next sample is accepted as
// soon as that register is loaded, even while the receiver stalls; a second
// result waits in the sequencer until the register is free.
// Reset clears the attack counter, loads the default threshold, slope and
// attack length, and empties the output register. Configuration is to be
// written only while no sample is in work.
// ---------------------------------------------------------------------------
module audio_db_compressor_with_attack_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [adc_pkg::CfgW-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,  // [15:0] sample_in
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata   // [15:0] sample_out
);
  import adc_pkg::*;

  cmd_t    cmd;
  status_t status;

  adc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  adc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: design/adc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_checker
// Port-level checks of the compressor core, bound to the top level.
// ---------------------------------------------------------------------------
module adc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("Stalled output request changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("Input taken while a sample is in work.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("Result appeared with no sample in work.");

endmodule

bind audio_db_compressor_with_attack_core adc_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
